// ----- design/pareto_front_ranker_unit_assert.svh -----
// Assertion macros shared by the checker.
`ifndef PARETO_FRONT_RANKER_UNIT_ASSERT_SVH
`define PARETO_FRONT_RANKER_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define PFR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pareto front ranker check failed");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define PFR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pareto front ranker check failed");

// Checked on every edge, reset included.
`define PFR_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("pareto front ranker check failed");

`endif

// ----- design/pfr_pkg.sv -----
package pfr_pkg;

   // Fixed field geometry.
   localparam int NUM_FIELDS     = 4;
   localparam int OBJ_W          = 16;
   localparam int NUM_OBJECTIVES = 4;
   localparam int OBJ_LIMIT      = (NUM_OBJECTIVES < NUM_FIELDS) ? NUM_OBJECTIVES : NUM_FIELDS;
   localparam int CFG_OBJ_W      = 3;
   localparam int IDX_W          = 6;
   localparam int RANK_W         = 6;
   localparam int REQ_DATA_W     = NUM_FIELDS * OBJ_W;
   localparam int RSP_DATA_W     = 16;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   // Register indexes (byte address bit 2).
   localparam logic CSR_IDX_MODE = 1'b0;
   localparam logic CSR_IDX_OBJS = 1'b1;

   typedef logic [REQ_DATA_W-1:0] obj_vec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK,
      ST_FIN,
      ST_RINIT,
      ST_RSCAN,
      ST_RNEXT,
      ST_EMRD,
      ST_EMLD,
      ST_EMWT
   } state_type;

   typedef struct packed {
      logic load;
      logic walk;
      logic fin;
      logic rinit;
      logic rscan;
      logic rnext;
      logic emrd;
      logic emld;
      logic emnext;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic last_in;
      logic walk_done;
      logic scan_done;
      logic next_empty;
      logic rsp_final;
   } status_type;

   // True when p is no worse than q in every active objective and better in one.
   function automatic logic dominates(input obj_vec_type p, input obj_vec_type q,
                                      input logic maxm, input logic [CFG_OBJ_W-1:0] nact);
      logic                    no_worse;
      logic                    strict;
      logic signed [OBJ_W-1:0] a;
      logic signed [OBJ_W-1:0] b;
      logic signed [OBJ_W-1:0] t;
      no_worse = 1'b1;
      strict   = 1'b0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
         a = p[k*OBJ_W +: OBJ_W];
         b = q[k*OBJ_W +: OBJ_W];
         if (maxm) begin
            t = a;
            a = b;
            b = t;
         end
         if (CFG_OBJ_W'(k) < nact) begin
            if (a > b) no_worse = 1'b0;
            if (a < b) strict = 1'b1;
         end
      end
      return no_worse & strict;
   endfunction

endpackage

// ----- design/pareto_front_ranker_unit.sv -----
// Loading: each individual that fits is compared with every stored individual in a walk through
// one read port of the objective and dominance stores; no input is taken during the walk.
// Ranking after the last individual: one scan over all stored individuals per front.
// Results: in load order, each read only after the previous one is taken; no input is taken
// until all are out.
// Reset is synchronous, active high: it clears control state and the configuration
// registers; the stores are not cleared and need no clearing pass.
module pareto_front_ranker_unit #(
   parameter int MAX_POP = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // objective_a, objective_b, objective_c, objective_d (16 bits each)
   input  logic [pfr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // member_index [5:0], front_rank [11:6], zeros above
   output logic [pfr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pfr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pfr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pfr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import pfr_pkg::*;

   logic                 maximize_ff;
   logic [CFG_OBJ_W-1:0] objs_ff;
   cmd_type              cmd;
   status_type           status;
   logic                 csr_wr;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         maximize_ff <= 1'b0;
         objs_ff     <= CFG_OBJ_W'(2);
      end else if (csr_wr) begin
         case (csr_paddr[2])
            CSR_IDX_MODE: maximize_ff <= csr_pwdata[0];
            CSR_IDX_OBJS: objs_ff     <= csr_pwdata[CFG_OBJ_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_MODE: csr_prdata = CSR_DATA_W'(maximize_ff);
         CSR_IDX_OBJS: csr_prdata = CSR_DATA_W'(objs_ff);
         default:      csr_prdata = '0;
      endcase
   end

   pfr_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready)
   );

   pfr_datapath #(
      .MAX_POP (MAX_POP)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .cfg_maximize (maximize_ff),
      .cfg_objs     (objs_ff),
      .rsp_tready   (rsp_tready),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ----- design/pfr_controller.sv -----
module pfr_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   input  logic                rsp_tready,
   input  pfr_pkg::status_type status,
   output pfr_pkg::cmd_type    cmd,
   output logic                req_tready
);
   import pfr_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands to the datapath.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (status.full) begin
                  state_in = req_tlast ? ST_RINIT : ST_IDLE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = status.last_in ? ST_RINIT : ST_IDLE;
         end
         ST_RINIT: begin
            cmd.rinit = 1'b1;
            state_in  = ST_RSCAN;
         end
         ST_RSCAN: begin
            cmd.rscan = 1'b1;
            if (status.scan_done) state_in = ST_RNEXT;
         end
         ST_RNEXT: begin
            cmd.rnext = 1'b1;
            state_in  = status.next_empty ? ST_EMRD : ST_RSCAN;
         end
         ST_EMRD: begin
            cmd.emrd = 1'b1;
            state_in = ST_EMLD;
         end
         ST_EMLD: begin
            cmd.emld = 1'b1;
            state_in = ST_EMWT;
         end
         ST_EMWT: begin
            if (rsp_tready) begin
               cmd.emnext = 1'b1;
               state_in   = status.rsp_final ? ST_IDLE : ST_EMRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/pfr_datapath.sv -----
module pfr_datapath #(
   parameter int MAX_POP = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pfr_pkg::cmd_type                cmd,
   input  logic [pfr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   input  logic                            cfg_maximize,
   input  logic [pfr_pkg::CFG_OBJ_W-1:0]   cfg_objs,
   input  logic                            rsp_tready,
   output pfr_pkg::status_type             status,
   output logic                            rsp_tvalid,
   output logic [pfr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import pfr_pkg::*;

   localparam int AW = $clog2(MAX_POP);
   localparam int CW = $clog2(MAX_POP + 1);

   // Stores, read data registered.
   obj_vec_type              obj_mem [MAX_POP];
   logic [MAX_POP-1:0]       dom_mem [MAX_POP];
   logic [RANK_W-1:0]        rank_mem [MAX_POP];
   obj_vec_type              obj_rd_ff;
   logic [MAX_POP-1:0]       dom_rd_ff;
   logic [RANK_W-1:0]        rank_rd_ff;

   // Control and lane state.
   logic [CW-1:0]            loaded_ff;
   logic [CW-1:0]            ptr_ff;
   logic [AW-1:0]            pd_ff;
   logic                     pend_ff;
   logic                     wvld_ff;
   logic                     rvld_ff;
   logic                     last_ff;
   obj_vec_type              cur_ff;
   logic [MAX_POP-1:0]       row_i_ff;
   logic [CW-1:0]            cnt_ff [MAX_POP];
   logic [MAX_POP-1:0]       mask_ff;
   logic [MAX_POP-1:0]       next_ff;
   logic [RANK_W-1:0]        rank_ff;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_idx_ff;
   logic [RANK_W-1:0]        rsp_rank_ff;
   logic                     rsp_final_ff;

   logic                     full;
   logic                     issue;
   logic [AW-1:0]            i_idx;
   logic [AW-1:0]            p_idx;
   logic [CFG_OBJ_W-1:0]     nact;
   logic                     kdi;
   logic                     idk;
   logic                     dom_we;
   logic [AW-1:0]            dom_wa;
   logic [MAX_POP-1:0]       dom_wd;
   logic                     rsp_final;

   assign full  = (loaded_ff == CW'(MAX_POP));
   assign issue = (cmd.walk | cmd.rscan) && (ptr_ff < loaded_ff);
   assign i_idx = loaded_ff[AW-1:0];
   assign p_idx = ptr_ff[AW-1:0];

   // Objective count clamped to the usable range.
   always_comb begin
      if (cfg_objs == '0) begin
         nact = CFG_OBJ_W'(1);
      end else if (cfg_objs > CFG_OBJ_W'(OBJ_LIMIT)) begin
         nact = CFG_OBJ_W'(OBJ_LIMIT);
      end else begin
         nact = cfg_objs;
      end
   end

   // Dominance both ways between the stored entry and the new individual.
   assign kdi = dominates(obj_rd_ff, cur_ff, cfg_maximize, nact);
   assign idk = dominates(cur_ff, obj_rd_ff, cfg_maximize, nact);

   // Dominance row write: mark the new individual in a dominating row, or close its own row.
   always_comb begin
      dom_we = 1'b0;
      dom_wa = pd_ff;
      dom_wd = dom_rd_ff | (MAX_POP'(1) << i_idx);
      if (cmd.fin) begin
         dom_we = 1'b1;
         dom_wa = i_idx;
         dom_wd = row_i_ff;
      end else if (wvld_ff && kdi) begin
         dom_we = 1'b1;
      end
   end

   assign rsp_final = (ptr_ff == loaded_ff - CW'(1));

   // Memories.
   always_ff @(posedge clock) begin
      if (cmd.load && !full) obj_mem[i_idx] <= req_tdata;
      if (issue) obj_rd_ff <= obj_mem[p_idx];
      if (dom_we) dom_mem[dom_wa] <= dom_wd;
      if (issue) dom_rd_ff <= dom_mem[p_idx];
      if (cmd.rscan && issue && mask_ff[p_idx]) rank_mem[p_idx] <= rank_ff;
      if (cmd.emrd) rank_rd_ff <= rank_mem[p_idx];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      pd_ff <= p_idx;
      if (cmd.emld) begin
         rsp_idx_ff   <= IDX_W'(p_idx);
         rsp_rank_ff  <= rank_rd_ff;
         rsp_final_ff <= rsp_final;
      end
   end

   // Dominator count lanes: built up while loading, drained while ranking.
   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_POP; j++) begin
         if (cmd.load && !full && (AW'(j) == i_idx)) begin
            cnt_ff[j] <= '0;
         end else if (wvld_ff) begin
            cnt_ff[j] <= cnt_ff[j] + CW'((AW'(j) == pd_ff) && idk)
                                   + CW'((AW'(j) == i_idx) && kdi);
         end else if (rvld_ff && dom_rd_ff[j] && (cnt_ff[j] != '0)) begin
            cnt_ff[j] <= cnt_ff[j] - CW'(1);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         wvld_ff      <= 1'b0;
         rvld_ff      <= 1'b0;
         row_i_ff     <= '0;
         mask_ff      <= '0;
         next_ff      <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= issue;
         wvld_ff <= issue && cmd.walk;
         rvld_ff <= issue && cmd.rscan && mask_ff[p_idx];

         // Walk pointer.
         if (cmd.load || cmd.rinit || cmd.rnext) begin
            ptr_ff <= '0;
         end else if (issue || (cmd.emnext && !rsp_final)) begin
            ptr_ff <= ptr_ff + CW'(1);
         end

         // Population size.
         if (cmd.fin) begin
            loaded_ff <= loaded_ff + CW'(1);
         end else if (cmd.emnext && rsp_final) begin
            loaded_ff <= '0;
         end

         // Row of the individual being loaded.
         if (cmd.load) begin
            row_i_ff <= '0;
         end else if (wvld_ff && idk) begin
            row_i_ff <= row_i_ff | (MAX_POP'(1) << pd_ff);
         end

         // Front masks and front number.
         if (cmd.rinit) begin
            for (int j = 0; j < MAX_POP; j++) begin
               mask_ff[j] <= (CW'(j) < loaded_ff) && (cnt_ff[j] == '0);
            end
            next_ff <= '0;
            rank_ff <= '0;
         end else if (cmd.rnext) begin
            mask_ff <= next_ff;
            next_ff <= '0;
            rank_ff <= rank_ff + RANK_W'(1);
         end else if (rvld_ff) begin
            for (int j = 0; j < MAX_POP; j++) begin
               if (dom_rd_ff[j] && (cnt_ff[j] == CW'(1))) next_ff[j] <= 1'b1;
            end
         end

         // Result register: loaded by the controller, freed by a transfer.
         if (cmd.emld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.full       = full;
   assign status.last_in    = last_ff;
   assign status.walk_done  = (ptr_ff == loaded_ff) && !pend_ff;
   assign status.scan_done  = (ptr_ff == loaded_ff) && !pend_ff;
   assign status.next_empty = (next_ff == '0);
   assign status.rsp_final  = rsp_final;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-IDX_W-RANK_W){1'b0}}, rsp_rank_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_final_ff;

endmodule

// ----- design/pfr_checker.sv -----
`include "pareto_front_ranker_unit_assert.svh"

module pfr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [pfr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pfr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [pfr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input logic [pfr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input logic [pfr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input logic                            csr_pready
);

   // A waiting result stays offered.
   `PFR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // No individual is taken while results of a population are being offered.
   `PFR_ASSERT_NOW(a_no_load_while_emit, rsp_tvalid, !req_tready)

   // A transfer that is not the final one leaves the block still emitting.
   `PFR_ASSERT_NEXT(a_emit_continues, rsp_tvalid && rsp_tready && !rsp_tlast, !req_tready)

   // Nothing is offered straight after reset.
   `PFR_ASSERT_ALWAYS(a_reset_quiet, reset, !rsp_tvalid)

endmodule

bind pareto_front_ranker_unit pfr_checker u_chk (.*);
